// ===== hw/rtl/ptss_pkg.sv =====
// Shared types and constants for the periodic task slot scheduler.
package ptss_pkg;

    localparam int unsigned NUM_SLOTS_DEF = 10;

    localparam int unsigned ACTION_W = 2;
    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned MASK_W   = 10;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned INDEX_W  = 4;
    localparam int unsigned TICK_W   = 32;

    localparam logic [ACTION_W-1:0] ACT_ATTACH = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_POLL   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK_RD,
        S_TICK_LOAD,
        S_TICK_DIV,
        S_TICK_CHK,
        S_FINISH
    } state_t;

endpackage

// ===== hw/rtl/ptss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ptss_ram #(
    parameter int unsigned WIDTH  = 16,
    parameter int unsigned DEPTH  = 10,
    parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/periodic_task_slot_scheduler_core.sv =====
// Periodic task slot scheduler: slot table, tick counter and modulo sequencer.
//
// Keeps up to NUM_SLOTS periodic slots and a wrapping 32-bit tick count.
// Slot periods live in a small RAM; active flags live in flip-flops cleared
// by reset. Attach, poll and unused actions answer in the cycle after they
// are taken. A tick walks the attached slots one at a time: each slot reads
// its period from the RAM and runs a 32-step restoring remainder unit in the
// read, load, divide and check states; the finish state issues the result.
// One item is worked on at a time; a new item is taken in the same cycle as
// the previous result, and the input stalls while a result waits to be taken.
module periodic_task_slot_scheduler_core #(
    parameter int unsigned NUM_SLOTS = ptss_pkg::NUM_SLOTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [ptss_pkg::ACTION_W-1:0]   action,
    input  logic [ptss_pkg::PERIOD_W-1:0]   period,
    input  logic [ptss_pkg::MASK_W-1:0]     done_mask,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ptss_pkg::STATUS_W-1:0]   status,
    output logic [ptss_pkg::INDEX_W-1:0]    slot_index,
    output logic [ptss_pkg::MASK_W-1:0]     active_mask,
    output logic [ptss_pkg::TICK_W-1:0]     tick_value
);

    import ptss_pkg::*;

    localparam int unsigned CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam int unsigned AW     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int unsigned STEP_W = $clog2(TICK_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TICK_W - 1);

    function automatic logic [MASK_W-1:0] mask_of(input logic [NUM_SLOTS-1:0] v);
        logic [31:0] e;
        e = 32'(v);
        return e[MASK_W-1:0];
    endfunction

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      slot_count_reg, slot_count_next;
    logic [TICK_W-1:0]     tick_count_reg, tick_count_next;
    logic [NUM_SLOTS-1:0]  active_reg, active_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [PERIOD_W-1:0]   period_reg, period_next;
    logic [PERIOD_W-1:0]   rem_reg, rem_next;
    logic [TICK_W-1:0]     shift_reg, shift_next;

    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [INDEX_W-1:0]    slot_index_reg, slot_index_next;
    logic [MASK_W-1:0]     active_mask_reg, active_mask_next;
    logic [TICK_W-1:0]     tick_value_reg, tick_value_next;

    logic                  ram_we;
    logic                  ram_re;
    logic [PERIOD_W-1:0]   ram_rdata;

    logic                  in_fire;
    logic                  out_fire;
    logic [31:0]           cnt_ext;
    logic [31:0]           done_ext;
    logic [PERIOD_W:0]     trial;
    logic                  trial_ge;

    ptss_ram #(
        .WIDTH (PERIOD_W),
        .DEPTH (NUM_SLOTS),
        .ADDR_W(AW)
    ) u_period_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(slot_count_reg[AW-1:0]),
        .wdata(period),
        .re   (ram_re),
        .raddr(idx_reg[AW-1:0]),
        .rdata(ram_rdata)
    );

    assign in_stall    = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign in_fire     = in_valid && !in_stall;
    assign out_fire    = out_valid_reg && !out_stall;
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign slot_index  = slot_index_reg;
    assign active_mask = active_mask_reg;
    assign tick_value  = tick_value_reg;

    assign cnt_ext  = 32'(slot_count_reg);
    assign done_ext = 32'(done_mask);
    assign trial    = {rem_reg, shift_reg[TICK_W-1]};
    assign trial_ge = trial >= {1'b0, period_reg};

    always_comb
    begin
        state_next       = state_reg;
        slot_count_next  = slot_count_reg;
        tick_count_next  = tick_count_reg;
        active_next      = active_reg;
        idx_next         = idx_reg;
        step_next        = step_reg;
        period_next      = period_reg;
        rem_next         = rem_reg;
        shift_next       = shift_reg;
        out_valid_next   = out_valid_reg;
        status_next      = status_reg;
        slot_index_next  = slot_index_reg;
        active_mask_next = active_mask_reg;
        tick_value_next  = tick_value_reg;
        ram_we           = 1'b0;
        ram_re           = 1'b0;

        if (out_fire)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    status_next     = ST_OK;
                    slot_index_next = '0;
                    tick_value_next = tick_count_reg;
                    case (action)
                        ACT_ATTACH:
                        begin
                            if (slot_count_reg >= CNT_W'(NUM_SLOTS))
                            begin
                                status_next = ST_FULL;
                            end
                            else if (period == '0)
                            begin
                                status_next = ST_ZERO;
                            end
                            else
                            begin
                                ram_we                           = 1'b1;
                                active_next[slot_count_reg[AW-1:0]] = 1'b1;
                                slot_count_next                  = slot_count_reg + 1'b1;
                                slot_index_next                  = cnt_ext[INDEX_W-1:0];
                            end
                            active_mask_next = mask_of(active_next);
                            out_valid_next   = 1'b1;
                        end
                        ACT_TICK:
                        begin
                            tick_count_next = tick_count_reg + 1'b1;
                            idx_next        = '0;
                            if (slot_count_reg == '0)
                            begin
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_TICK_RD;
                            end
                        end
                        ACT_POLL:
                        begin
                            active_mask_next = mask_of(active_reg);
                            active_next      = active_reg & ~done_ext[NUM_SLOTS-1:0];
                            out_valid_next   = 1'b1;
                        end
                        default:
                        begin
                            active_mask_next = mask_of(active_reg);
                            out_valid_next   = 1'b1;
                        end
                    endcase
                end
            end
            S_TICK_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_TICK_LOAD;
            end
            S_TICK_LOAD:
            begin
                period_next = ram_rdata;
                rem_next    = '0;
                shift_next  = tick_count_reg;
                step_next   = '0;
                state_next  = S_TICK_DIV;
            end
            S_TICK_DIV:
            begin
                if (trial_ge)
                begin
                    rem_next = PERIOD_W'(trial - {1'b0, period_reg});
                end
                else
                begin
                    rem_next = trial[PERIOD_W-1:0];
                end
                shift_next = {shift_reg[TICK_W-2:0], 1'b0};
                step_next  = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_TICK_CHK;
                end
            end
            S_TICK_CHK:
            begin
                if (rem_reg == '0)
                begin
                    active_next[idx_reg[AW-1:0]] = 1'b1;
                end
                if (idx_reg + 1'b1 == slot_count_reg)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_TICK_RD;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg)
                begin
                    status_next      = ST_OK;
                    slot_index_next  = '0;
                    active_mask_next = mask_of(active_reg);
                    tick_value_next  = tick_count_reg;
                    out_valid_next   = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            slot_count_reg <= '0;
            tick_count_reg <= '0;
            active_reg     <= '0;
            idx_reg        <= '0;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            slot_count_reg <= slot_count_next;
            tick_count_reg <= tick_count_next;
            active_reg     <= active_next;
            idx_reg        <= idx_next;
            step_reg       <= step_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        period_reg      <= period_next;
        rem_reg         <= rem_next;
        shift_reg       <= shift_next;
        status_reg      <= status_next;
        slot_index_reg  <= slot_index_next;
        active_mask_reg <= active_mask_next;
        tick_value_reg  <= tick_value_next;
    end

endmodule
